// ----- rtl/dtoi_pkg.sv -----
// shared types, character codes and limits for the decimal text parser
package dtoi_pkg;

  localparam int VALUE_BITS = 32;

  typedef logic [VALUE_BITS-1:0] mag_t;

  // magnitude limits: positive side 2^(n-1)-1, negative side 2^(n-1)
  localparam mag_t MAG_LIMIT_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam mag_t MAG_LIMIT_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam mag_t MAG_DIV10_POS = MAG_LIMIT_POS / 10;
  localparam mag_t MAG_DIV10_NEG = MAG_LIMIT_NEG / 10;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_FAIL   = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   negative;
    mag_t   mag;
  } scan_state_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } byte_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] parsed_value;
    logic                         parse_ok;
  } result_t;

endpackage

// ----- rtl/decimal_text_to_int32_parser.sv -----
// top level: streaming saturating decimal text to signed integer parser
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------
//  byte    | in        | byte_valid / byte_stall    | text_byte, last_byte
//  result  | out       | result_valid / result_stall | parsed_value, parse_ok
//
// one character per cycle while byte_stall is low; the scan state updates in the same cycle a byte is taken
// a result appears in the cycle after the transaction carrying the last byte
// the only loop is the times-ten accumulate and limit compare in dtoi_step
// reset returns the scan to the leading whitespace phase and empties the result register
// byte_stall rises only while a result waits and result_stall is high
//
module decimal_text_to_int32_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  dtoi_pkg::byte_t   byte_data,
  output logic              result_valid,
  input  logic              result_stall,
  output dtoi_pkg::result_t result_data
);

  localparam dtoi_pkg::scan_state_t SCAN_RESET = '{
    phase:    dtoi_pkg::PH_LEAD,
    negative: 1'b0,
    mag:      '0
  };

  dtoi_pkg::scan_state_t scan;
  dtoi_pkg::scan_state_t scan_next;
  dtoi_pkg::mag_t        value_next;
  logic                  ok_next;
  logic                  byte_take;
  logic                  result_take;

  // the result register is the only thing that can hold up the input
  assign byte_stall  = result_valid && result_stall;
  assign byte_take   = byte_valid && !byte_stall;
  assign result_take = result_valid && !result_stall;

  dtoi_step u_step (
    .cur       (scan),
    .text_byte (byte_data.text_byte),
    .nxt       (scan_next)
  );

  // two's complement of the magnitude for negative strings
  always_comb begin
    value_next = scan_next.negative ? (~scan_next.mag + 1'b1) : scan_next.mag;
    ok_next    = (scan_next.phase == dtoi_pkg::PH_DIGITS) ||
                 (scan_next.phase == dtoi_pkg::PH_TRAIL);
  end

  // scan state: back to reset after the last byte of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= SCAN_RESET;
    end else if (byte_take) begin
      if (byte_data.last_byte) begin
        scan <= SCAN_RESET;
      end else begin
        scan <= scan_next;
      end
    end
  end

  // result register, loads on the last byte and drains when not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (byte_take && byte_data.last_byte) begin
      result_valid <= 1'b1;
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && byte_data.last_byte) begin
      result_data.parsed_value <= $signed(value_next);
      result_data.parse_ok     <= ok_next;
    end
  end

  // a last-byte transaction always leaves a result behind it
  assert property (@(posedge clk) disable iff (rst)
    byte_take && byte_data.last_byte |=> result_valid)
    else $error("last byte taken without a result");

  // each string starts from a clean scan state
  assert property (@(posedge clk) disable iff (rst)
    byte_take && byte_data.last_byte |=>
      (scan.phase == dtoi_pkg::PH_LEAD) && !scan.negative && (scan.mag == '0))
    else $error("scan state not cleared after last byte");

  // no magnitude can build up before the first digit
  assert property (@(posedge clk) disable iff (rst)
    (scan.phase == dtoi_pkg::PH_LEAD) || (scan.phase == dtoi_pkg::PH_SIGN) |->
      (scan.mag == '0))
    else $error("magnitude set before any digit");

  // a stalled result that is still waiting must not be overwritten
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("waiting result lost or changed");

endmodule

// ----- rtl/dtoi_step.sv -----
// next scan state for one character: classify, multiply-accumulate, saturate
module dtoi_step (
  input  dtoi_pkg::scan_state_t cur,
  input  logic [7:0]            text_byte,
  output dtoi_pkg::scan_state_t nxt
);

  logic           is_digit;
  logic           is_space;
  logic           is_sign;
  logic [3:0]     digit;
  dtoi_pkg::mag_t limit;
  dtoi_pkg::mag_t limit_div10;
  dtoi_pkg::mag_t times_ten;
  dtoi_pkg::mag_t acc_mag;
  logic           acc_over;

  always_comb begin
    is_digit = (text_byte >= dtoi_pkg::CHAR_ZERO) && (text_byte <= dtoi_pkg::CHAR_NINE);
    is_space = (text_byte == dtoi_pkg::CHAR_SPACE) ||
               ((text_byte >= dtoi_pkg::CHAR_TAB) && (text_byte <= dtoi_pkg::CHAR_CR));
    is_sign  = (text_byte == dtoi_pkg::CHAR_PLUS) || (text_byte == dtoi_pkg::CHAR_MINUS);
    // ascii digits carry their value in the low nibble
    digit    = text_byte[3:0];

    limit       = cur.negative ? dtoi_pkg::MAG_LIMIT_NEG : dtoi_pkg::MAG_LIMIT_POS;
    limit_div10 = cur.negative ? dtoi_pkg::MAG_DIV10_NEG : dtoi_pkg::MAG_DIV10_POS;
    // times ten as shift-add; only meaningful when mag <= limit/10
    times_ten   = (cur.mag << 3) + (cur.mag << 1);
    acc_over    = (cur.mag > limit_div10) ||
                  (times_ten > (limit - dtoi_pkg::mag_t'(digit)));
    acc_mag     = acc_over ? limit : (times_ten + dtoi_pkg::mag_t'(digit));

    nxt = cur;
    unique case (cur.phase)
      dtoi_pkg::PH_LEAD: begin
        if (is_space) begin
          nxt.phase = dtoi_pkg::PH_LEAD;
        end else if (is_sign) begin
          nxt.negative = (text_byte == dtoi_pkg::CHAR_MINUS);
          nxt.phase    = dtoi_pkg::PH_SIGN;
        end else if (is_digit) begin
          nxt.negative = 1'b0;
          nxt.mag      = acc_mag;
          nxt.phase    = acc_over ? dtoi_pkg::PH_FAIL : dtoi_pkg::PH_DIGITS;
        end else begin
          nxt.phase = dtoi_pkg::PH_FAIL;
        end
      end
      dtoi_pkg::PH_SIGN, dtoi_pkg::PH_DIGITS: begin
        if (is_digit) begin
          nxt.mag   = acc_mag;
          nxt.phase = acc_over ? dtoi_pkg::PH_FAIL : dtoi_pkg::PH_DIGITS;
        end else if (is_space && (cur.phase == dtoi_pkg::PH_DIGITS)) begin
          nxt.phase = dtoi_pkg::PH_TRAIL;
        end else begin
          nxt.phase = dtoi_pkg::PH_FAIL;
        end
      end
      dtoi_pkg::PH_TRAIL: begin
        if (!is_space) begin
          nxt.phase = dtoi_pkg::PH_FAIL;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule
